/* rtl/nsfc_pkg.sv */
// Shared types, constants and helper functions of the sentence framer and checker.
`timescale 1ns / 1ps

package nsfc_pkg;

   // Longest line kept, '$' included
   localparam int MAX_LINE = 120;
   localparam int CNT_W    = $clog2(MAX_LINE + 1);
   localparam int FIELD_W  = 7;
   localparam int RSP_W    = 24;

   // Characters with a meaning to the framer
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_NL     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;

   // Sentence type tails, first character in the high byte
   localparam logic [23:0] TAIL_RMC = "RMC";
   localparam logic [23:0] TAIL_GGA = "GGA";
   localparam logic [23:0] TAIL_GSA = "GSA";
   localparam logic [23:0] TAIL_GSV = "GSV";
   localparam logic [23:0] TAIL_VTG = "VTG";

   typedef enum logic [2:0] {
      KIND_OTHER = 3'd0,
      KIND_RMC   = 3'd1,
      KIND_GGA   = 3'd2,
      KIND_GSA   = 3'd3,
      KIND_GSV   = 3'd4,
      KIND_VTG   = 3'd5
   } nsfc_kind_type;

   // Line state carried from byte to byte
   typedef struct packed {
      logic                line_open;
      logic [CNT_W-1:0]    char_count;
      logic [7:0]          running_xor;
      logic [7:0]          xor_before_star;
      logic                star_seen;
      logic [CNT_W-1:0]    star_position;
      logic [1:0]          hex_count;
      logic [7:0]          hex_hi;
      logic [7:0]          hex_lo;
      logic [CNT_W-1:0]    cr_run;
      logic [CNT_W-1:0]    comma_count;
      logic [CNT_W-1:0]    commas_before_star;
      logic                first_comma_seen;
      logic [23:0]         last_three;
      nsfc_kind_type       kind_at_comma;
      nsfc_kind_type       kind_at_star;
   } nsfc_line_type;

   // Hex digit value: bit 4 set when the character is a digit
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      v = 5'd0;
      if (c >= "0" && c <= "9") begin
         v = {1'b1, 4'(c - "0")};
      end else if (c >= "a" && c <= "f") begin
         v = {1'b1, 4'(c - "a" + 8'd10)};
      end else if (c >= "A" && c <= "F") begin
         v = {1'b1, 4'(c - "A" + 8'd10)};
      end
      return v;
   endfunction

   // Sentence type from the last three characters of the first field
   function automatic nsfc_kind_type kind_of(input logic valid, input logic [23:0] tail);
      nsfc_kind_type k;
      k = KIND_OTHER;
      if (valid) begin
         if (tail == TAIL_RMC)      k = KIND_RMC;
         else if (tail == TAIL_GGA) k = KIND_GGA;
         else if (tail == TAIL_GSA) k = KIND_GSA;
         else if (tail == TAIL_GSV) k = KIND_GSV;
         else if (tail == TAIL_VTG) k = KIND_VTG;
      end
      return k;
   endfunction

   // Minimum field count for a known type
   function automatic logic [FIELD_W-1:0] min_fields(input nsfc_kind_type k);
      logic [FIELD_W-1:0] m;
      unique case (k)
         KIND_RMC: m = FIELD_W'(10);
         KIND_GGA: m = FIELD_W'(12);
         KIND_GSA: m = FIELD_W'(18);
         KIND_GSV: m = FIELD_W'(4);
         KIND_VTG: m = FIELD_W'(8);
         default:  m = '0;
      endcase
      return m;
   endfunction

endpackage

/* rtl/nmea_sentence_framer_checker.sv */
// Top level of the NMEA sentence framer and checksum checker.
// A newline passes from the input register to the result register, where
// rsp_tvalid rises and the result waits until it is taken.
// Throughput: one byte per cycle; a newline waits in the input register only
// while the previous result is held in the result register and not taken.
// Reset: synchronous, active high; clears the line state and both valid flags.
`timescale 1ns / 1ps

module nmea_sentence_framer_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [0] checksum_ok, [3:1] sentence_kind,
                                    // [4] recognized, [11:5] field_count,
                                    // [18:12] line_length, [23:19] zero
);

   logic                    rsp_busy;
   logic                    finish;
   nsfc_pkg::nsfc_line_type line_snap;

   nsfc_track u_track (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_busy   (rsp_busy),
      .finish     (finish),
      .line_snap  (line_snap)
   );

   nsfc_eval u_eval (
      .clock      (clock),
      .reset      (reset),
      .finish     (finish),
      .line_snap  (line_snap),
      .rsp_busy   (rsp_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* rtl/nsfc_track.sv */
// Input register and per-byte line state of the sentence framer.
`timescale 1ns / 1ps

module nsfc_track (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,
   input  logic                   rsp_busy,
   output logic                   finish,
   output nsfc_pkg::nsfc_line_type line_snap
);

   logic                    in_valid_ff;
   logic [7:0]              in_byte_ff;
   nsfc_pkg::nsfc_line_type line_ff;
   nsfc_pkg::nsfc_line_type line_in;
   logic                    is_nl;
   logic                    advance;
   logic                    tail_valid;

   // Hold a newline while the previous result still waits
   assign is_nl      = (in_byte_ff == nsfc_pkg::CHAR_NL);
   assign advance    = in_valid_ff && !(is_nl && rsp_busy);
   assign req_tready = !in_valid_ff || advance;
   assign finish     = advance && is_nl;
   assign line_snap  = line_ff;
   assign tail_valid = (line_ff.char_count >= nsfc_pkg::CNT_W'(4));

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   // Next line state for the byte in the input register
   always_comb begin
      line_in = line_ff;
      if (is_nl) begin
         line_in = '0;
      end else if (in_byte_ff == nsfc_pkg::CHAR_DOLLAR) begin
         line_in            = '0;
         line_in.line_open  = 1'b1;
         line_in.char_count = nsfc_pkg::CNT_W'(1);
      end else if (!line_ff.line_open) begin
         line_in = line_ff;
      end else if (line_ff.char_count >= nsfc_pkg::CNT_W'(nsfc_pkg::MAX_LINE)) begin
         line_in = '0;
      end else begin
         // Capture the two characters after the last star
         if (line_ff.star_seen) begin
            if (line_ff.hex_count == 2'd0) begin
               line_in.hex_hi    = in_byte_ff;
               line_in.hex_lo    = 8'd0;
               line_in.hex_count = 2'd1;
            end else if (line_ff.hex_count == 2'd1) begin
               line_in.hex_lo    = in_byte_ff;
               line_in.hex_count = 2'd2;
            end
         end
         if (in_byte_ff == nsfc_pkg::CHAR_STAR) begin
            line_in.star_seen          = 1'b1;
            line_in.star_position      = line_ff.char_count;
            line_in.xor_before_star    = line_ff.running_xor;
            line_in.commas_before_star = line_ff.comma_count;
            line_in.kind_at_star       = nsfc_pkg::kind_of(tail_valid, line_ff.last_three);
            line_in.hex_hi             = 8'd0;
            line_in.hex_lo             = 8'd0;
            line_in.hex_count          = 2'd0;
         end else if (in_byte_ff == nsfc_pkg::CHAR_COMMA) begin
            if (!line_ff.first_comma_seen) begin
               line_in.kind_at_comma    = nsfc_pkg::kind_of(tail_valid, line_ff.last_three);
               line_in.first_comma_seen = 1'b1;
            end
            line_in.comma_count = line_ff.comma_count + nsfc_pkg::CNT_W'(1);
         end
         line_in.running_xor = line_ff.running_xor ^ in_byte_ff;
         line_in.last_three  = {line_ff.last_three[15:0], in_byte_ff};
         line_in.cr_run      = (in_byte_ff == nsfc_pkg::CHAR_CR) ?
                               line_ff.cr_run + nsfc_pkg::CNT_W'(1) : '0;
         line_in.char_count  = line_ff.char_count + nsfc_pkg::CNT_W'(1);
      end
   end

   // Line state register
   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff <= '0;
      end else if (advance) begin
         line_ff <= line_in;
      end
   end

endmodule

/* rtl/nsfc_eval.sv */
// Line evaluation at newline and the result register.
`timescale 1ns / 1ps

module nsfc_eval (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           finish,
   input  nsfc_pkg::nsfc_line_type        line_snap,
   output logic                           rsp_busy,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [nsfc_pkg::RSP_W-1:0]     rsp_tdata
);

   logic                          out_valid_ff;
   logic [nsfc_pkg::RSP_W-1:0]    out_data_ff;
   logic [nsfc_pkg::RSP_W-1:0]    out_data_in;
   logic [nsfc_pkg::CNT_W-1:0]    len;
   logic [nsfc_pkg::CNT_W:0]      star_end;
   logic [nsfc_pkg::CNT_W-1:0]    commas;
   logic [nsfc_pkg::FIELD_W-1:0]  fields;
   logic [nsfc_pkg::FIELD_W-1:0]  len_out;
   logic [4:0]                    d0;
   logic [4:0]                    d1;
   logic [7:0]                    want;
   logic                          shape_ok;
   logic                          ok;
   nsfc_pkg::nsfc_kind_type       kind;
   logic                          rec;

   // Stripped length, field count and where the checksum ends
   assign len      = line_snap.char_count - line_snap.cr_run;
   assign star_end = {1'b0, line_snap.star_position} + (nsfc_pkg::CNT_W + 1)'(3);
   assign commas   = line_snap.star_seen ? line_snap.commas_before_star : line_snap.comma_count;
   assign fields   = line_snap.line_open ?
                     nsfc_pkg::FIELD_W'(commas + nsfc_pkg::CNT_W'(1)) : '0;
   assign len_out  = nsfc_pkg::FIELD_W'(len);

   // Read up to two hex digits, stop at the first non-digit
   assign d0   = nsfc_pkg::hex_value(line_snap.hex_hi);
   assign d1   = nsfc_pkg::hex_value(line_snap.hex_lo);
   assign want = !d0[4] ? 8'd0 : (d1[4] ? {d0[3:0], d1[3:0]} : {4'd0, d0[3:0]});

   assign shape_ok = line_snap.line_open && line_snap.star_seen &&
                     (len >= nsfc_pkg::CNT_W'(4)) && (star_end <= {1'b0, len});
   assign ok       = shape_ok && (want == line_snap.xor_before_star);

   // Sentence type and field minimum
   always_comb begin
      kind = nsfc_pkg::KIND_OTHER;
      if (ok) begin
         kind = (line_snap.commas_before_star != '0) ? line_snap.kind_at_comma
                                                     : line_snap.kind_at_star;
      end
   end
   assign rec = ok && (kind != nsfc_pkg::KIND_OTHER) && (fields >= nsfc_pkg::min_fields(kind));

   assign out_data_in = {5'd0, len_out, fields, rec, kind, ok};

   // Result register: load on newline, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (finish) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (finish) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_busy   = out_valid_ff && !rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

/* rtl/nsfc_checker.sv */
// Port-level checks of the sentence framer, bound to the top level.
`timescale 1ns / 1ps

module nsfc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   // Hold a stalled result transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // Recognized implies a good checksum
   a_rec_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[4] || rsp_tdata[0])
      else $error("recognized without checksum");

   // Bad checksum reports no sentence type
   a_kind_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[3:1] == 3'd0)
      else $error("type reported on bad checksum");

   // Only a newline byte leads to a result
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |->
         $past(req_tvalid && req_tready && req_tdata == nsfc_pkg::CHAR_NL, 2))
      else $error("result without newline");

   // Result channel is empty after each reset cycle
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind nmea_sentence_framer_checker nsfc_checker u_nsfc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* test/tb_nmea_sentence_framer_checker.sv */
// Testbench for the NMEA sentence framer and checksum checker.
`timescale 1ns / 1ps

module tb_nmea_sentence_framer_checker;

   // One report per newline, rsp_tdata fields in reverse order, without padding
   typedef struct packed {
      logic                    ok;
      nsfc_pkg::nsfc_kind_type kind;
      logic                    rec;
      logic [6:0]              fields;
      logic [6:0]              len;
   } sentence_report_type;

   // Receiver pacing patterns
   typedef enum int {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_TOGGLE
   } ready_pattern_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;            // [0] checksum_ok, [3:1] sentence_kind,
                                      // [4] recognized, [11:5] field_count,
                                      // [18:12] line_length, [23:19] zero

   sentence_report_type expected_reports[$];
   logic [7:0]          line_bytes[$];
   logic [7:0]          body_xor;
   int                  mismatch_count    = 0;
   int                  bytes_accepted    = 0;
   int                  reports_predicted = 0;
   int                  burst_left        = 0;

   // Line state of the predictor
   logic                       ln_open;
   logic [nsfc_pkg::CNT_W-1:0] ln_count;
   logic [nsfc_pkg::CNT_W-1:0] ln_star_pos;
   logic [nsfc_pkg::CNT_W-1:0] ln_cr_run;
   logic [nsfc_pkg::CNT_W-1:0] ln_commas;
   logic [nsfc_pkg::CNT_W-1:0] ln_commas_at_star;
   logic [7:0]                 ln_xor;
   logic [7:0]                 ln_xor_at_star;
   logic [7:0]                 ln_hex_hi;
   logic [7:0]                 ln_hex_lo;
   logic                       ln_star_seen;
   logic                       ln_comma_seen;
   logic [23:0]                ln_last3;
   logic [24:0]                ln_tail_comma;
   logic [24:0]                ln_tail_star;

   ready_pattern_type ready_pattern = READY_ALWAYS;
   int                pattern_left  = 0;

   nmea_sentence_framer_checker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic int hex_digit(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return -1;
   endfunction

   // Bit 24 marks a first field of at least three characters
   function automatic nsfc_pkg::nsfc_kind_type tail_kind(input logic [24:0] tail);
      nsfc_pkg::nsfc_kind_type k;
      k = nsfc_pkg::KIND_OTHER;
      if (tail[24]) begin
         unique case (tail[23:0])
            nsfc_pkg::TAIL_RMC: k = nsfc_pkg::KIND_RMC;
            nsfc_pkg::TAIL_GGA: k = nsfc_pkg::KIND_GGA;
            nsfc_pkg::TAIL_GSA: k = nsfc_pkg::KIND_GSA;
            nsfc_pkg::TAIL_GSV: k = nsfc_pkg::KIND_GSV;
            nsfc_pkg::TAIL_VTG: k = nsfc_pkg::KIND_VTG;
            default:            k = nsfc_pkg::KIND_OTHER;
         endcase
      end
      return k;
   endfunction

   function automatic int fields_needed(input nsfc_pkg::nsfc_kind_type k);
      int n;
      unique case (k)
         nsfc_pkg::KIND_RMC: n = 10;
         nsfc_pkg::KIND_GGA: n = 12;
         nsfc_pkg::KIND_GSA: n = 18;
         nsfc_pkg::KIND_GSV: n = 4;
         nsfc_pkg::KIND_VTG: n = 8;
         default:            n = 0;
      endcase
      return n;
   endfunction

   task automatic clear_line();
      ln_open           = 1'b0;
      ln_count          = '0;
      ln_star_pos       = '0;
      ln_cr_run         = '0;
      ln_commas         = '0;
      ln_commas_at_star = '0;
      ln_xor            = '0;
      ln_xor_at_star    = '0;
      ln_hex_hi         = '0;
      ln_hex_lo         = '0;
      ln_star_seen      = 1'b0;
      ln_comma_seen     = 1'b0;
      ln_last3          = '0;
      ln_tail_comma     = '0;
      ln_tail_star      = '0;
   endtask

   // Work out the report that a newline produces
   task automatic report_line();
      sentence_report_type        r;
      logic [nsfc_pkg::CNT_W-1:0] len;
      int                         hi, lo, wanted;
      r = '0;
      if (ln_open) begin
         len      = ln_count - ln_cr_run;
         r.len    = len;
         r.fields = (ln_star_seen ? ln_commas_at_star : ln_commas) + 1'b1;
         if (len >= 4 && ln_star_seen && int'(ln_star_pos) + 3 <= int'(len)) begin
            hi     = hex_digit(ln_hex_hi);
            lo     = hex_digit(ln_hex_lo);
            wanted = 0;
            if (hi >= 0) wanted = (lo >= 0) ? hi * 16 + lo : hi;
            r.ok   = (wanted == int'(ln_xor_at_star));
         end
         if (r.ok) begin
            r.kind = tail_kind(ln_commas_at_star != 0 ? ln_tail_comma : ln_tail_star);
            r.rec  = (r.kind != nsfc_pkg::KIND_OTHER) &&
                     (int'(r.fields) >= fields_needed(r.kind));
         end
      end
      expected_reports.insert(expected_reports.size(), r);
      reports_predicted++;
   endtask

   // Advance the line state by one accepted byte
   task automatic predict_byte(input logic [7:0] c);
      logic [nsfc_pkg::CNT_W-1:0] idx;
      if (c == nsfc_pkg::CHAR_NL) begin
         report_line();
         clear_line();
      end else if (c == nsfc_pkg::CHAR_DOLLAR) begin
         clear_line();
         ln_open  = 1'b1;
         ln_count = nsfc_pkg::CNT_W'(1);
      end else if (ln_open && ln_count >= nsfc_pkg::MAX_LINE) begin
         clear_line();
      end else if (ln_open) begin
         idx = ln_count;
         if (ln_star_seen) begin
            if (idx == ln_star_pos + 1) begin
               ln_hex_hi = c;
               ln_hex_lo = '0;
            end else if (idx == ln_star_pos + 2) begin
               ln_hex_lo = c;
            end
         end
         if (c == nsfc_pkg::CHAR_STAR) begin
            ln_star_seen      = 1'b1;
            ln_star_pos       = idx;
            ln_xor_at_star    = ln_xor;
            ln_commas_at_star = ln_commas;
            ln_tail_star      = {ln_count >= 4, ln_last3};
            ln_hex_hi         = '0;
            ln_hex_lo         = '0;
         end else if (c == nsfc_pkg::CHAR_COMMA) begin
            if (!ln_comma_seen) begin
               ln_tail_comma = {ln_count >= 4, ln_last3};
               ln_comma_seen = 1'b1;
            end
            ln_commas = ln_commas + 1'b1;
         end
         ln_xor    = ln_xor ^ c;
         ln_last3  = {ln_last3[15:0], c};
         ln_cr_run = (c == nsfc_pkg::CHAR_CR) ? ln_cr_run + 1'b1 : '0;
         ln_count  = idx + 1'b1;
      end
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch in %s: got %0d, expected %0d (at %0t)", what, got, want, $time);
      mismatch_count++;
   endtask

   // Compare each result transaction with the oldest expected report
   always @(posedge clock) begin : check_results
      sentence_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_reports.size() == 0) begin
            report_mismatch("unexpected result", int'(rsp_tdata), 0);
         end else begin
            want = expected_reports.pop_front();
            if (rsp_tdata[0] !== want.ok)
               report_mismatch("checksum_ok", int'(rsp_tdata[0]), int'(want.ok));
            if (rsp_tdata[3:1] !== want.kind)
               report_mismatch("sentence_kind", int'(rsp_tdata[3:1]), int'(want.kind));
            if (rsp_tdata[4] !== want.rec)
               report_mismatch("recognized", int'(rsp_tdata[4]), int'(want.rec));
            if (rsp_tdata[11:5] !== want.fields)
               report_mismatch("field_count", int'(rsp_tdata[11:5]), int'(want.fields));
            if (rsp_tdata[18:12] !== want.len)
               report_mismatch("line_length", int'(rsp_tdata[18:12]), int'(want.len));
            if (rsp_tdata[23:19] !== 5'd0)
               report_mismatch("padding", int'(rsp_tdata[23:19]), 0);
         end
      end
   end

   // Stall the result channel on patterns, each held for a random stretch
   always @(posedge clock) begin
      if (pattern_left == 0) begin
         ready_pattern = ready_pattern_type'($urandom_range(0, 3));
         pattern_left  = $urandom_range(16, 96);
      end else begin
         pattern_left--;
      end
      unique case (ready_pattern)
         READY_ALWAYS: rsp_tready <= 1'b1;
         READY_COIN:   rsp_tready <= ($urandom_range(0, 1) == 1);
         READY_SPARSE: rsp_tready <= ($urandom_range(0, 5) == 0);
         default:      rsp_tready <= ~rsp_tready;
      endcase
   end

   // ---------------------------------------------------------------- stimulus

   // Send one byte; the sender works in bursts with random gaps between them
   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_byte(b);
      bytes_accepted++;
   endtask

   task automatic send_line();
      foreach (line_bytes[i]) send_byte(line_bytes[i]);
      line_bytes.delete();
   endtask

   // Queue one byte at the end of the line under construction
   task automatic append_byte(input logic [7:0] c);
      line_bytes.insert(line_bytes.size(), c);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) append_byte(s[i]);
   endtask

   // Append a character that counts toward the checksum
   task automatic put_body(input logic [7:0] c);
      append_byte(c);
      body_xor = body_xor ^ c;
   endtask

   function automatic logic [7:0] pick_char(input string set);
      return set[$urandom_range(0, set.len() - 1)];
   endfunction

   // Any byte that neither starts nor ends a line
   function automatic logic [7:0] noise_char();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (c == nsfc_pkg::CHAR_DOLLAR || c == nsfc_pkg::CHAR_NL);
      return c;
   endfunction

   function automatic logic [7:0] field_char();
      int r;
      r = $urandom_range(0, 39);
      if (r == 0) return nsfc_pkg::CHAR_STAR;
      if (r == 1) return nsfc_pkg::CHAR_CR;
      if (r == 2) return noise_char();
      return pick_char("0123456789.NSEWAMV");
   endfunction

   // Build one sentence with random content and a random checksum form
   task automatic build_sentence();
      int    pick, nfields, form;
      string tail;
      if ($urandom_range(0, 7) == 0)
         repeat ($urandom_range(1, 3)) append_byte(noise_char());
      if ($urandom_range(0, 11) == 0) add_text("$GPGG");
      append_byte(nsfc_pkg::CHAR_DOLLAR);
      body_xor = '0;
      pick     = $urandom_range(0, 6);
      case (pick)
         0: begin tail = "RMC"; nfields = 10; end
         1: begin tail = "GGA"; nfields = 12; end
         2: begin tail = "GSA"; nfields = 18; end
         3: begin tail = "GSV"; nfields = 4;  end
         4: begin tail = "VTG"; nfields = 8;  end
         default: begin tail = ""; nfields = $urandom_range(1, 8); end
      endcase
      // talker, then the type tail
      if (pick < 6) begin
         case ($urandom_range(0, 3))
            0: begin put_body("G"); put_body("P"); end
            1: begin put_body("G"); put_body("N"); end
            2: ;
            default: put_body(pick_char("ABCDEFGHIJKLMNOPQRSTUVWXYZ"));
         endcase
      end
      if (pick == 5) begin
         repeat (3) put_body(pick_char("ABCDEFGHIJKLMNOPQRSTUVWXYZ"));
      end else if (pick == 6) begin
         repeat ($urandom_range(0, 2)) put_body(pick_char("GRMCSVTA"));
      end else begin
         for (int i = 0; i < tail.len(); i++) put_body(tail[i]);
      end
      nfields = nfields + int'($urandom_range(0, 4)) - 2;
      if (nfields < 1) nfields = 1;
      for (int f = 1; f < nfields; f++) begin
         put_body(nsfc_pkg::CHAR_COMMA);
         repeat ($urandom_range(0, 3)) put_body(field_char());
      end
      // checksum: mostly correct, else wrong, short, signed or missing
      form = $urandom_range(0, 11);
      if (form != 10) append_byte(nsfc_pkg::CHAR_STAR);
      case (form)
         5:  add_text($sformatf("%02x", body_xor));
         6:  add_text($sformatf("%02X", body_xor ^ (8'h01 << $urandom_range(0, 7))));
         7:  begin
            if (body_xor < 16) add_text($sformatf("%XG", body_xor[3:0]));
            else add_text($sformatf("%X,", body_xor[7:4]));
         end
         8:  begin
            append_byte(pick_char("+- "));
            add_text($sformatf("%X", body_xor[3:0]));
         end
         9:  add_text($sformatf("%X", body_xor[7:4]));
         10: ;
         11: repeat (2) append_byte(noise_char());
         default: add_text($sformatf("%02X", body_xor));
      endcase
      if ($urandom_range(0, 5) == 0)
         repeat ($urandom_range(1, 3)) append_byte(pick_char("AB,0"));
      repeat ($urandom_range(0, 3)) append_byte(nsfc_pkg::CHAR_CR);
      if ($urandom_range(0, 19) != 0) append_byte(nsfc_pkg::CHAR_NL);
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_idle_newline();
      append_byte(nsfc_pkg::CHAR_NL);
      send_line();
   endtask

   // Shortest valid sentence, trailing carriage returns stripped
   task automatic test_minimal_sentence();
      add_text("$*00");
      append_byte(nsfc_pkg::CHAR_CR);
      append_byte(nsfc_pkg::CHAR_CR);
      append_byte(nsfc_pkg::CHAR_NL);
      send_line();
   endtask

   // A sign before the digits reads as zero
   task automatic test_sign_before_digits();
      add_text("$*-5");
      append_byte(nsfc_pkg::CHAR_NL);
      send_line();
   endtask

   // A carriage return inside the line is kept and folded into the checksum
   task automatic test_carriage_return_in_body();
      append_byte(nsfc_pkg::CHAR_DOLLAR);
      append_byte(nsfc_pkg::CHAR_CR);
      add_text("*0D");
      append_byte(nsfc_pkg::CHAR_NL);
      send_line();
   endtask

   // Bytes outside a line are dropped; a second start character restarts
   task automatic test_restart_and_ignored();
      add_text("k$Z$*00");
      append_byte(nsfc_pkg::CHAR_NL);
      send_line();
   endtask

   // Lines around the length limit, with valid checksums
   task automatic test_long_lines();
      int body_len, crs;
      for (int n = 0; n < 3; n++) begin
         body_len = (n < 2) ? 116 : $urandom_range(108, 118);
         crs      = (n == 0) ? 0 : (n == 1) ? 1 : $urandom_range(0, 2);
         append_byte(nsfc_pkg::CHAR_DOLLAR);
         body_xor = '0;
         repeat (body_len) put_body(pick_char("0123456789,.ABC"));
         append_byte(nsfc_pkg::CHAR_STAR);
         add_text($sformatf("%02X", body_xor));
         repeat (crs) append_byte(nsfc_pkg::CHAR_CR);
         append_byte(nsfc_pkg::CHAR_NL);
         send_line();
      end
   endtask

   // Raw bytes with frequent start and newline characters
   task automatic test_noise();
      int r;
      repeat (80) begin
         r = $urandom_range(0, 9);
         if (r == 0) append_byte(nsfc_pkg::CHAR_DOLLAR);
         else if (r == 1) append_byte(nsfc_pkg::CHAR_NL);
         else append_byte(8'($urandom_range(0, 255)));
      end
      send_line();
   endtask

   // Random sentences until the run holds about 650 bytes
   task automatic test_sentences();
      while (bytes_accepted < 650) begin
         build_sentence();
         send_line();
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      clear_line();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_idle_newline();
      test_minimal_sentence();
      test_sign_before_digits();
      test_carriage_return_in_body();
      test_restart_and_ignored();
      test_long_lines();
      test_noise();
      test_sentences();
      req_tvalid <= 1'b0;

      // drain outstanding reports, then watch for strays
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Hang guard
   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

/* filelist.f */
rtl/nsfc_pkg.sv
rtl/nsfc_track.sv
rtl/nsfc_eval.sv
rtl/nmea_sentence_framer_checker.sv
rtl/nsfc_checker.sv
test/tb_nmea_sentence_framer_checker.sv
